// File: hdl/rycc_pkg.sv
// shared types and constants for the rgb/ycbcr full range converter
package rycc_pkg;

  localparam int WORD_W = 16;
  localparam int COEF_W = 18;
  localparam int OPND_W = 17;
  localparam int PROD_W = COEF_W + OPND_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int FRAC_BITS = 16;
  localparam int NCHAN = 3;

  typedef logic [WORD_W-1:0]        word_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [OPND_W-1:0] opnd_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic {
    DIR_FWD = 1'b0,
    DIR_INV = 1'b1
  } dir_t;

  typedef enum logic [2:0] {
    PV_FULL        = 3'd0,
    PV_GRAY_C0     = 3'd1,
    PV_GRAY_C1     = 3'd2,
    PV_GRAY_C2     = 3'd3,
    PV_KEEP_C0     = 3'd4,
    PV_KEEP_C1     = 3'd5,
    PV_KEEP_C2     = 3'd6,
    PV_KEEP_C0_ALT = 3'd7
  } pv_t;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DIRECTION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PREVIEW   = 1'b1;

  // q16 coefficients, row per output channel, column per input channel
  localparam coef_t COEF_FWD [NCHAN][NCHAN] = '{
    '{ 18'sd19595,  18'sd38470,  18'sd7471 },
    '{-18'sd11056, -18'sd21712,  18'sd32768},
    '{ 18'sd32768, -18'sd27440, -18'sd5328 }
  };

  localparam coef_t COEF_INV [NCHAN][NCHAN] = '{
    '{18'sd65536,  18'sd0,      18'sd91881},
    '{18'sd65536, -18'sd22554, -18'sd46802},
    '{18'sd65536,  18'sd116130, 18'sd0    }
  };

  localparam acc_t ROUND_HALF = acc_t'(64'd1 << (FRAC_BITS - 1));

endpackage

// File: hdl/rgb_ycbcr_full_range_convert_unit.sv
// top level of the rgb/ycbcr full range converter
//
// Converts one pixel per word between RGB and full-range YCbCr (JFIF coefficients).
// Input channel: in_valid / in_stall with three samples and a last-pixel mark.
// Result channel: out_valid / out_stall with three saturated samples and the mark.
// Configuration: cfg_we writes cfg_data into the register chosen by cfg_index
// (0 direction, 1 preview mode); write only while no word is in flight.
// Pipeline: input register, product register, result register; a word passes
// through them in that order. One word per cycle is sustained while out_stall is low,
// set by the three registered stages each taking a word per clock.
// A stalled result holds; empty stages still fill behind it, and in_stall rises
// only once every stage holds a word that cannot move.
// Reset (rst_n low at a clock edge) empties all stages and sets direction to
// forward and preview mode to full conversion.
// SAMPLE_BITS sets the sample range; higher input bits are ignored.
module rgb_ycbcr_full_range_convert_unit #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rycc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rycc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rycc_pkg::WORD_W-1:0]         in_chan0_in,
  input  logic [rycc_pkg::WORD_W-1:0]         in_chan1_in,
  input  logic [rycc_pkg::WORD_W-1:0]         in_chan2_in,
  input  logic                                in_pixel_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rycc_pkg::WORD_W-1:0]         out_chan0_out,
  output logic [rycc_pkg::WORD_W-1:0]         out_chan1_out,
  output logic [rycc_pkg::WORD_W-1:0]         out_chan2_out,
  output logic                                out_pixel_last_out
);

  localparam int V_W = rycc_pkg::ACC_W - rycc_pkg::FRAC_BITS;
  localparam rycc_pkg::word_t SMASK =
    rycc_pkg::WORD_W'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam rycc_pkg::word_t SMID16 = rycc_pkg::WORD_W'(64'd1 << (SAMPLE_BITS - 1));
  localparam rycc_pkg::opnd_t SMID17 = rycc_pkg::OPND_W'(64'd1 << (SAMPLE_BITS - 1));
  localparam rycc_pkg::acc_t CHROMA_BIAS =
    rycc_pkg::ACC_W'(64'd1 << (SAMPLE_BITS - 1 + rycc_pkg::FRAC_BITS));
  localparam logic [V_W-1:0] SMAX_V = V_W'(SMASK);

  // configuration
  rycc_pkg::dir_t dir_r;
  rycc_pkg::pv_t  pv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= rycc_pkg::DIR_FWD;
      pv_r  <= rycc_pkg::PV_FULL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rycc_pkg::CFG_IDX_DIRECTION: dir_r <= rycc_pkg::dir_t'(cfg_data[0]);
        rycc_pkg::CFG_IDX_PREVIEW:   pv_r  <= rycc_pkg::pv_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // stage handshake
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic s1_move, s2_move, out_move;

  assign out_move = !out_valid_r || !out_stall;
  assign s2_move  = !s2_valid_r || out_move;
  assign s1_move  = !s1_valid_r || s2_move;
  assign in_stall = !s1_move;

  // stage 1: masked input samples
  rycc_pkg::word_t s1_chan_r [rycc_pkg::NCHAN];
  logic            s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_move) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && in_valid) begin
      s1_chan_r[0] <= in_chan0_in & SMASK;
      s1_chan_r[1] <= in_chan1_in & SMASK;
      s1_chan_r[2] <= in_chan2_in & SMASK;
      s1_last_r    <= in_pixel_last;
    end
  end

  // stage 2: preview select and products
  rycc_pkg::word_t ch    [rycc_pkg::NCHAN];
  rycc_pkg::opnd_t opnd  [rycc_pkg::NCHAN];
  rycc_pkg::coef_t coef_sel [rycc_pkg::NCHAN][rycc_pkg::NCHAN];
  rycc_pkg::prod_t s2_prod_nxt [rycc_pkg::NCHAN][rycc_pkg::NCHAN];
  rycc_pkg::prod_t s2_prod_r   [rycc_pkg::NCHAN][rycc_pkg::NCHAN];
  logic            s2_gray_nxt, s2_gray_r;
  rycc_pkg::word_t s2_gray_val_nxt, s2_gray_val_r;
  logic            s2_last_r;

  always_comb begin
    ch              = s1_chan_r;
    s2_gray_nxt     = 1'b0;
    s2_gray_val_nxt = s1_chan_r[0];
    if (dir_r == rycc_pkg::DIR_INV) begin
      case (pv_r) inside
        rycc_pkg::PV_GRAY_C0: begin
          s2_gray_nxt     = 1'b1;
          s2_gray_val_nxt = s1_chan_r[0];
        end
        rycc_pkg::PV_GRAY_C1: begin
          s2_gray_nxt     = 1'b1;
          s2_gray_val_nxt = s1_chan_r[1];
        end
        rycc_pkg::PV_GRAY_C2: begin
          s2_gray_nxt     = 1'b1;
          s2_gray_val_nxt = s1_chan_r[2];
        end
        rycc_pkg::PV_KEEP_C0, rycc_pkg::PV_KEEP_C0_ALT: begin
          ch[1] = SMID16;
          ch[2] = SMID16;
        end
        rycc_pkg::PV_KEEP_C1: begin
          ch[0] = SMID16;
          ch[2] = SMID16;
        end
        rycc_pkg::PV_KEEP_C2: begin
          ch[0] = SMID16;
          ch[1] = SMID16;
        end
        default: ;
      endcase
    end
    for (int i = 0; i < rycc_pkg::NCHAN; i++) begin
      if (dir_r == rycc_pkg::DIR_INV && i != 0) begin
        opnd[i] = {1'b0, ch[i]} - SMID17;
      end else begin
        opnd[i] = {1'b0, ch[i]};
      end
    end
    for (int j = 0; j < rycc_pkg::NCHAN; j++) begin
      for (int i = 0; i < rycc_pkg::NCHAN; i++) begin
        coef_sel[j][i] = (dir_r == rycc_pkg::DIR_INV) ? rycc_pkg::COEF_INV[j][i]
                                                      : rycc_pkg::COEF_FWD[j][i];
        s2_prod_nxt[j][i] = coef_sel[j][i] * opnd[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_move) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move && s1_valid_r) begin
      s2_prod_r     <= s2_prod_nxt;
      s2_gray_r     <= s2_gray_nxt;
      s2_gray_val_r <= s2_gray_val_nxt;
      s2_last_r     <= s1_last_r;
    end
  end

  // stage 3: sum, round half up, saturate, or pass the gray preview sample
  function automatic rycc_pkg::word_t round_sat(input rycc_pkg::acc_t acc);
    logic [V_W-1:0] v;
    v = acc[rycc_pkg::ACC_W-1:rycc_pkg::FRAC_BITS];
    if (acc[rycc_pkg::ACC_W-1]) begin
      return '0;
    end else if (v > SMAX_V) begin
      return SMASK;
    end else begin
      return v[rycc_pkg::WORD_W-1:0];
    end
  endfunction

  rycc_pkg::acc_t  acc [rycc_pkg::NCHAN];
  rycc_pkg::word_t out_chan_nxt [rycc_pkg::NCHAN];
  rycc_pkg::word_t out_chan_r   [rycc_pkg::NCHAN];
  logic            out_last_r;

  always_comb begin
    for (int j = 0; j < rycc_pkg::NCHAN; j++) begin
      acc[j] = rycc_pkg::ACC_W'(s2_prod_r[j][0]) + rycc_pkg::ACC_W'(s2_prod_r[j][1])
             + rycc_pkg::ACC_W'(s2_prod_r[j][2]) + rycc_pkg::ROUND_HALF;
      if (dir_r == rycc_pkg::DIR_FWD && j != 0) begin
        acc[j] = acc[j] + CHROMA_BIAS;
      end
      out_chan_nxt[j] = s2_gray_r ? s2_gray_val_r : round_sat(acc[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_move) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_move && s2_valid_r) begin
      out_chan_r <= out_chan_nxt;
      out_last_r <= s2_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_chan0_out      = out_chan_r[0];
  assign out_chan1_out      = out_chan_r[1];
  assign out_chan2_out      = out_chan_r[2];
  assign out_pixel_last_out = out_last_r;

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s2_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_move) |=> s1_valid_r)
    else $error("stage 1 word lost while blocked");

  a_s2_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !out_move) |=> (s2_valid_r && $stable(s2_last_r)))
    else $error("stage 2 word lost while blocked");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_chan_r[0] <= SMASK && out_chan_r[1] <= SMASK
                     && out_chan_r[2] <= SMASK))
    else $error("result beyond sample range");

  a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_gray_r && out_move) |=>
      (out_chan_r[0] == out_chan_r[1] && out_chan_r[1] == out_chan_r[2]))
    else $error("gray preview channels differ");

endmodule
